FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Each use names its label, its property or expression, and its message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

FILE: rtl/sbf_pkg.sv
package sbf_pkg;

  typedef enum logic [1:0] {
    FUNC_SPRITE = 2'd0,
    FUNC_CLEAR  = 2'd1,
    FUNC_SET_BG = 2'd2,
    FUNC_READ   = 2'd3
  } sbf_func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_MUL,
    ST_LEFT,
    ST_RIGHT,
    ST_BG_SWEEP,
    ST_BG_DRAIN,
    ST_RD_ADDR,
    ST_RD_DATA
  } sbf_state_e;

  // Write controls for the index and mark stores.
  typedef struct packed {
    logic       idx_we;
    logic [3:0] idx_wdata;
    logic       mark_we;
    logic       mark_wdata;
  } sbf_wr_t;

  localparam logic [3:0] ColorKey = 4'h0;

  localparam logic [31:0] Palette [16] = '{
    32'hFF000000, 32'hFF000000, 32'hFF888888, 32'hFF3239BF,
    32'hFFAE7ADE, 32'hFF213D4C, 32'hFF255F90, 32'hFF5294E4,
    32'hFF79D9EA, 32'hFF3B7A53, 32'hFF4AD5AB, 32'hFF382E25,
    32'hFF7F4600, 32'hFFCCAB68, 32'hFFE4DEBC, 32'hFFFFFFFF
  };

endpackage

FILE: rtl/sprite_blit_framebuffer.sv
// Channel | Direction | Handshake                | Payload
// in      | input     | in_valid_i / in_stall_o  | func_i .. pixel_address_i
// out     | output    | out_valid_o / out_stall_i | pixel_argb_o
//
// A sprite byte steps through accept, row multiply, left pixel and right pixel.
// A read passes the address and data states, waiting while the output register is held;
// clear and set background sweep one pixel per cycle through the adder.
// After reset a clearing pass over all W*H pixels (76800 by default) holds in_stall_o.
// A finished read waits in the output register; a new word is taken meanwhile,
// and only a second read stalls until that register is free.
`include "assert_macros.svh"

module sprite_blit_framebuffer #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic signed [15:0] sprite_x_i,
  input  logic signed [15:0] sprite_y_i,
  input  logic [7:0]         sprite_width_i,
  input  logic [7:0]         sprite_height_i,
  input  logic               first_byte_i,
  input  logic [7:0]         sprite_byte_i,
  input  logic [3:0]         background_i,
  input  logic [16:0]        pixel_address_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        pixel_argb_o
);

  localparam int Npix = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW   = $clog2(Npix);

  logic [AW-1:0]    rd_addr, wr_addr;
  sbf_pkg::sbf_wr_t wr;
  logic [3:0]       idx_rd;
  logic             mark_rd;
  logic             res_load, res_in_range;
  logic             out_valid_q;
  logic [31:0]      argb_q;

  sbf_seq #(
    .Width  (SCREEN_WIDTH),
    .Height (SCREEN_HEIGHT)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .sprite_x_i      (sprite_x_i),
    .sprite_y_i      (sprite_y_i),
    .sprite_width_i  (sprite_width_i),
    .sprite_height_i (sprite_height_i),
    .first_byte_i    (first_byte_i),
    .sprite_byte_i   (sprite_byte_i),
    .background_i    (background_i),
    .pixel_address_i (pixel_address_i),
    .out_busy_i      (out_valid_q && out_stall_i),
    .mark_rd_i       (mark_rd),
    .rd_addr_o       (rd_addr),
    .wr_addr_o       (wr_addr),
    .wr_o            (wr),
    .res_load_o      (res_load),
    .res_in_range_o  (res_in_range)
  );

  sbf_frame_store #(
    .Npix (Npix)
  ) u_store (
    .clk_i     (clk_i),
    .wr_addr_i (wr_addr),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .idx_rd_o  (idx_rd),
    .mark_rd_o (mark_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // An address past the screen reads as black with zero alpha.
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      argb_q <= res_in_range ? sbf_pkg::Palette[idx_rd] : 32'h0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_argb_o = argb_q;

  `ASSERT_AT(a_valid_from_read, $rose(out_valid_q) |-> $past(res_load), "output word without a read")

endmodule

FILE: rtl/sbf_alu.sv
// Shared adder with range flags for the linear pixel address.
module sbf_alu #(
  parameter int SumW = 29,
  parameter int Npix = 76800
) (
  input  logic signed [SumW-1:0] a_i,
  input  logic signed [SumW-1:0] b_i,
  output logic signed [SumW-1:0] sum_o,
  output logic                   in_range_o,
  output logic                   at_end_o
);

  localparam logic signed [SumW-1:0] NpixS = SumW'(Npix);

  assign sum_o      = a_i + b_i;
  assign in_range_o = !sum_o[SumW-1] && (sum_o < NpixS);
  assign at_end_o   = (sum_o == NpixS);

endmodule

FILE: rtl/sbf_frame_store.sv
// Pixel index store and background mark store, one write and one read port each.
module sbf_frame_store #(
  parameter int Npix = 76800
) (
  input  logic                    clk_i,
  input  logic [$clog2(Npix)-1:0] wr_addr_i,
  input  sbf_pkg::sbf_wr_t        wr_i,
  input  logic [$clog2(Npix)-1:0] rd_addr_i,
  output logic [3:0]              idx_rd_o,
  output logic                    mark_rd_o
);

  logic [3:0] idx_mem  [Npix];
  logic       mark_mem [Npix];

  always_ff @(posedge clk_i) begin
    if (wr_i.idx_we) begin
      idx_mem[wr_addr_i] <= wr_i.idx_wdata;
    end
    idx_rd_o <= idx_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.mark_we) begin
      mark_mem[wr_addr_i] <= wr_i.mark_wdata;
    end
    mark_rd_o <= mark_mem[rd_addr_i];
  end

endmodule

FILE: rtl/sbf_seq.sv
`include "assert_macros.svh"

// Sequencer: steps one word through the shared address adder.
module sbf_seq #(
  parameter int Width  = 320,
  parameter int Height = 240
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               func_i,
  input  logic signed [15:0]       sprite_x_i,
  input  logic signed [15:0]       sprite_y_i,
  input  logic [7:0]               sprite_width_i,
  input  logic [7:0]               sprite_height_i,
  input  logic                     first_byte_i,
  input  logic [7:0]               sprite_byte_i,
  input  logic [3:0]               background_i,
  input  logic [16:0]              pixel_address_i,
  input  logic                     out_busy_i,
  input  logic                     mark_rd_i,
  output logic [$clog2(Width*Height)-1:0] rd_addr_o,
  output logic [$clog2(Width*Height)-1:0] wr_addr_o,
  output sbf_pkg::sbf_wr_t         wr_o,
  output logic                     res_load_o,
  output logic                     res_in_range_o
);

  localparam int Npix = Width * Height;
  localparam int AW   = $clog2(Npix);
  localparam int SumW = 17 + $clog2(Width) + 3;
  localparam logic signed [SumW-1:0] WidthS = SumW'(Width);
  localparam logic signed [SumW-1:0] NpixS  = SumW'(Npix);
  localparam logic signed [SumW-1:0] OneS   = SumW'(1);

  sbf_pkg::sbf_state_e state_q, state_d;

  logic signed [SumW-1:0] addr_q;
  logic signed [SumW-1:0] off_q;
  logic signed [15:0]     sx_q;
  logic signed [15:0]     sy_q;
  logic [7:0]             w_q;
  logic [7:0]             h_q;
  logic [7:0]             byte_q;
  logic [3:0]             bg_idx_q;
  logic [7:0]             col_q, col_d;
  logic [7:0]             row_q, row_d;
  logic                   wvld_q;
  logic [AW-1:0]          waddr_q;
  logic                   rng_q;

  logic                   in_acc;
  logic signed [SumW-1:0] alu_a, alu_b, alu_sum;
  logic                   alu_in_range, alu_at_end;
  logic signed [16:0]     row_sum;
  logic signed [SumW-1:0] prod;
  logic signed [SumW-1:0] off;
  logic [8:0]             nc, nr;
  sbf_pkg::sbf_func_e     func;

  assign func       = sbf_pkg::sbf_func_e'(func_i);
  assign in_stall_o = (state_q != sbf_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign rd_addr_o  = addr_q[AW-1:0];

  sbf_alu #(
    .SumW (SumW),
    .Npix (Npix)
  ) u_alu (
    .a_i        (alu_a),
    .b_i        (alu_b),
    .sum_o      (alu_sum),
    .in_range_o (alu_in_range),
    .at_end_o   (alu_at_end)
  );

  // Row base and column offset of the current byte.
  assign row_sum = 17'(sy_q) + $signed({9'b0, row_q});
  assign prod    = SumW'(row_sum) * WidthS;
  assign off     = SumW'(sx_q) + SumW'($signed({8'b0, col_q, 1'b0}));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sbf_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (func)
            sbf_pkg::FUNC_SPRITE: state_d = sbf_pkg::ST_MUL;
            sbf_pkg::FUNC_CLEAR:  state_d = sbf_pkg::ST_CLEAR;
            sbf_pkg::FUNC_SET_BG: state_d = sbf_pkg::ST_BG_SWEEP;
            sbf_pkg::FUNC_READ:   state_d = sbf_pkg::ST_RD_ADDR;
            default:              state_d = sbf_pkg::ST_IDLE;
          endcase
        end
      end
      sbf_pkg::ST_CLEAR: begin
        if (alu_at_end) state_d = sbf_pkg::ST_IDLE;
      end
      sbf_pkg::ST_MUL:   state_d = sbf_pkg::ST_LEFT;
      sbf_pkg::ST_LEFT:  state_d = sbf_pkg::ST_RIGHT;
      sbf_pkg::ST_RIGHT: state_d = sbf_pkg::ST_IDLE;
      sbf_pkg::ST_BG_SWEEP: begin
        if (alu_at_end) state_d = sbf_pkg::ST_BG_DRAIN;
      end
      sbf_pkg::ST_BG_DRAIN: state_d = sbf_pkg::ST_IDLE;
      sbf_pkg::ST_RD_ADDR:  state_d = sbf_pkg::ST_RD_DATA;
      sbf_pkg::ST_RD_DATA: begin
        if (!out_busy_i) state_d = sbf_pkg::ST_IDLE;
      end
      default: state_d = sbf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    alu_a          = addr_q;
    alu_b          = OneS;
    wr_addr_o      = alu_sum[AW-1:0];
    wr_o           = '0;
    res_load_o     = 1'b0;
    res_in_range_o = rng_q;
    unique case (state_q)
      sbf_pkg::ST_LEFT: begin
        alu_b = off_q;
        if (alu_in_range) begin
          wr_o.mark_we    = 1'b1;
          wr_o.mark_wdata = (byte_q[7:4] == sbf_pkg::ColorKey);
          wr_o.idx_we     = (byte_q[7:4] != sbf_pkg::ColorKey);
          wr_o.idx_wdata  = byte_q[7:4];
        end
      end
      sbf_pkg::ST_RIGHT: begin
        if (alu_in_range) begin
          wr_o.mark_we    = 1'b1;
          wr_o.mark_wdata = (byte_q[3:0] == sbf_pkg::ColorKey);
          wr_o.idx_we     = (byte_q[3:0] != sbf_pkg::ColorKey);
          wr_o.idx_wdata  = byte_q[3:0];
        end
      end
      sbf_pkg::ST_CLEAR: begin
        wr_addr_o       = addr_q[AW-1:0];
        wr_o.idx_we     = 1'b1;
        wr_o.idx_wdata  = bg_idx_q;
        wr_o.mark_we    = 1'b1;
        wr_o.mark_wdata = 1'b1;
      end
      sbf_pkg::ST_BG_SWEEP, sbf_pkg::ST_BG_DRAIN: begin
        // The mark read in the previous cycle decides the repaint of that pixel.
        wr_addr_o      = waddr_q;
        wr_o.idx_we    = wvld_q && mark_rd_i;
        wr_o.idx_wdata = bg_idx_q;
      end
      sbf_pkg::ST_RD_ADDR: begin
        alu_b = '0;
      end
      sbf_pkg::ST_RD_DATA: begin
        res_load_o = !out_busy_i;
      end
      sbf_pkg::ST_IDLE, sbf_pkg::ST_MUL: begin
        alu_b = OneS;
      end
      default: begin
        alu_b = OneS;
      end
    endcase
  end

  // Column and row counters of the sprite being drawn.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    nc    = {1'b0, col_q} + 9'd1;
    nr    = {1'b0, row_q};
    if (in_acc && func == sbf_pkg::FUNC_SPRITE && first_byte_i) begin
      col_d = '0;
      row_d = '0;
    end else if (state_q == sbf_pkg::ST_RIGHT) begin
      if (nc >= {1'b0, w_q}) begin
        nc = '0;
        nr = nr + 9'd1;
        if (nr >= {1'b0, h_q}) begin
          nr = '0;
        end
      end
      col_d = nc[7:0];
      row_d = nr[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // Reset starts in the clear sweep so the stores get their initial contents.
      state_q  <= sbf_pkg::ST_CLEAR;
      addr_q   <= '0;
      bg_idx_q <= '0;
      col_q    <= '0;
      row_q    <= '0;
      wvld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      wvld_q  <= (state_q == sbf_pkg::ST_BG_SWEEP);
      if (in_acc) begin
        if (func == sbf_pkg::FUNC_READ) begin
          addr_q <= SumW'(pixel_address_i);
        end else begin
          addr_q <= '0;
        end
        if (func == sbf_pkg::FUNC_SET_BG) begin
          bg_idx_q <= background_i;
        end
      end else if (state_q == sbf_pkg::ST_MUL) begin
        addr_q <= prod;
      end else if (state_q == sbf_pkg::ST_LEFT || state_q == sbf_pkg::ST_CLEAR ||
                   state_q == sbf_pkg::ST_BG_SWEEP) begin
        addr_q <= alu_sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sx_q   <= sprite_x_i;
      sy_q   <= sprite_y_i;
      w_q    <= sprite_width_i;
      h_q    <= sprite_height_i;
      byte_q <= sprite_byte_i;
    end
    if (state_q == sbf_pkg::ST_MUL) begin
      off_q <= off;
    end
    if (state_q == sbf_pkg::ST_RD_ADDR) begin
      rng_q <= alu_in_range;
    end
    waddr_q <= addr_q[AW-1:0];
  end

  `ASSERT_AT(a_no_overrun, res_load_o |-> !out_busy_i, "result loaded over a held word")
  `ASSERT_AT(a_wvld_bg, wvld_q |-> (state_q == sbf_pkg::ST_BG_SWEEP || state_q == sbf_pkg::ST_BG_DRAIN), "repaint write outside the sweep")
  `ASSERT_AT(a_clear_addr, (state_q == sbf_pkg::ST_CLEAR) |-> (!addr_q[SumW-1] && addr_q < NpixS), "clear address out of range")

endmodule

FILE: test/sprite_blit_framebuffer_tb.sv
module sprite_blit_framebuffer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCR_W = 320;
  localparam int SCR_H = 240;
  localparam int NPIX  = SCR_W * SCR_H;
  localparam int RANDOM_WORDS = 1000;
  localparam int MAX_SWEEPS   = 5;

  localparam logic [31:0] COLOR_LUT [16] = '{
    32'hFF000000, 32'hFF000000, 32'hFF888888, 32'hFF3239BF,
    32'hFFAE7ADE, 32'hFF213D4C, 32'hFF255F90, 32'hFF5294E4,
    32'hFF79D9EA, 32'hFF3B7A53, 32'hFF4AD5AB, 32'hFF382E25,
    32'hFF7F4600, 32'hFFCCAB68, 32'hFFE4DEBC, 32'hFFFFFFFF
  };

  // One input word plus, for rows of the directed table, a color typed in by hand.
  typedef struct packed {
    sbf_pkg::sbf_func_e func;
    logic [15:0] sx;
    logic [15:0] sy;
    logic [7:0]  w;
    logic [7:0]  h;
    logic        first;
    logic [7:0]  pix;
    logic [3:0]  bg;
    logic [16:0] addr;
    logic        chk;
    logic [31:0] want;
  } blit_word_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [1:0]  func_i          = 2'd0;
  logic [15:0] sprite_x_i      = 16'd0;
  logic [15:0] sprite_y_i      = 16'd0;
  logic [7:0]  sprite_width_i  = 8'd0;
  logic [7:0]  sprite_height_i = 8'd0;
  logic        first_byte_i    = 1'b0;
  logic [7:0]  sprite_byte_i   = 8'd0;
  logic [3:0]  background_i    = 4'd0;
  logic [16:0] pixel_address_i = 17'd0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [31:0] pixel_argb_o;

  sprite_blit_framebuffer #(
    .SCREEN_WIDTH (SCR_W),
    .SCREEN_HEIGHT(SCR_H)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .sprite_x_i     (sprite_x_i),
    .sprite_y_i     (sprite_y_i),
    .sprite_width_i (sprite_width_i),
    .sprite_height_i(sprite_height_i),
    .first_byte_i   (first_byte_i),
    .sprite_byte_i  (sprite_byte_i),
    .background_i   (background_i),
    .pixel_address_i(pixel_address_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_argb_o   (pixel_argb_o)
  );

  // Shadow copy of the frame store and the blitter's registers.
  logic [3:0]  fb_index [NPIX];
  bit          fb_mark  [NPIX];
  logic [3:0]  bg_reg;
  logic [7:0]  col_cnt;
  logic [7:0]  row_cnt;

  logic [31:0] color_q [$];
  bit          no_idle = 1'b0;
  int          n_words, n_bytes, n_reads, n_sweeps, n_checked, n_bad;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d colors still pending", color_q.size());
    $display("sprite_blit_framebuffer test failed");
    $finish;
  end

  function automatic void plot(longint a, logic [3:0] nib);
    if (a < 0 || a >= NPIX) return;
    if (nib == 4'h0) begin
      fb_mark[a] = 1'b1;
    end else begin
      fb_index[a] = nib;
      fb_mark[a]  = 1'b0;
    end
  endfunction

  // Updates the shadow state for one word; returns 1 with the color when a read.
  function automatic bit blit_apply(input blit_word_t wd, output logic [31:0] argb);
    longint base;
    int     nc, nr;
    argb = 32'd0;
    case (wd.func)
      sbf_pkg::FUNC_SPRITE: begin
        if (wd.first) begin
          col_cnt = 8'd0;
          row_cnt = 8'd0;
        end
        base = (longint'($signed(wd.sy)) + longint'(row_cnt)) * SCR_W
             + longint'($signed(wd.sx)) + 2 * longint'(col_cnt);
        plot(base, wd.pix[7:4]);
        plot(base + 1, wd.pix[3:0]);
        nc = int'(col_cnt) + 1;
        nr = int'(row_cnt);
        if (nc >= int'(wd.w)) begin
          nc = 0;
          nr = nr + 1;
          if (nr >= int'(wd.h)) nr = 0;
        end
        col_cnt = nc[7:0];
        row_cnt = nr[7:0];
        return 1'b0;
      end
      sbf_pkg::FUNC_CLEAR: begin
        for (int i = 0; i < NPIX; i++) begin
          fb_index[i] = bg_reg;
          fb_mark[i]  = 1'b1;
        end
        return 1'b0;
      end
      sbf_pkg::FUNC_SET_BG: begin
        for (int i = 0; i < NPIX; i++) begin
          if (fb_mark[i]) fb_index[i] = wd.bg;
        end
        bg_reg = wd.bg;
        return 1'b0;
      end
      default: begin
        if (int'(wd.addr) < NPIX) argb = COLOR_LUT[fb_index[wd.addr]];
        return 1'b1;
      end
    endcase
  endfunction

  function automatic blit_word_t noise_word();
    blit_word_t wd;
    wd.func  = sbf_pkg::FUNC_SPRITE;
    wd.sx    = 16'($urandom);
    wd.sy    = 16'($urandom);
    wd.w     = 8'($urandom);
    wd.h     = 8'($urandom);
    wd.first = 1'($urandom);
    wd.pix   = 8'($urandom);
    wd.bg    = 4'($urandom);
    wd.addr  = 17'($urandom);
    wd.chk   = 1'b0;
    wd.want  = 32'd0;
    return wd;
  endfunction

  function automatic blit_word_t spr(logic [15:0] sx, logic [15:0] sy, logic [7:0] w,
                                     logic [7:0] h, logic first, logic [7:0] pix);
    blit_word_t wd;
    wd       = noise_word();
    wd.sx    = sx;
    wd.sy    = sy;
    wd.w     = w;
    wd.h     = h;
    wd.first = first;
    wd.pix   = pix;
    return wd;
  endfunction

  function automatic blit_word_t rd(logic [16:0] addr, logic chk, logic [31:0] want);
    blit_word_t wd;
    wd      = noise_word();
    wd.func = sbf_pkg::FUNC_READ;
    wd.addr = addr;
    wd.chk  = chk;
    wd.want = want;
    return wd;
  endfunction

  function automatic blit_word_t op(sbf_pkg::sbf_func_e func, logic [3:0] bg);
    blit_word_t wd;
    wd      = noise_word();
    wd.func = func;
    wd.bg   = bg;
    return wd;
  endfunction

  function automatic logic [7:0] pick_dim();
    case ($urandom_range(0, 19))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom);
      default: return 8'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [3:0] rand_nib();
    return ($urandom_range(0, 3) == 0) ? 4'h0 : 4'($urandom_range(1, 15));
  endfunction

  // An address in the sprite's footprint; a random on-screen one if that falls outside 17 bits.
  function automatic logic [16:0] foot_addr(logic [15:0] sx, logic [15:0] sy,
                                            logic [7:0] w, logic [7:0] h);
    longint a;
    a = (longint'($signed(sy)) + longint'($urandom_range(0, (h == 0) ? 0 : h - 1))) * SCR_W
      + longint'($signed(sx)) + longint'($urandom_range(0, (w == 0) ? 1 : 2 * w - 1));
    if (a < 0 || a > 131071) a = longint'($urandom_range(0, NPIX - 1));
    return 17'(a);
  endfunction

  task automatic send_word(input blit_word_t wd);
    int          gap;
    logic [31:0] argb;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    func_i          <= wd.func;
    sprite_x_i      <= wd.sx;
    sprite_y_i      <= wd.sy;
    sprite_width_i  <= wd.w;
    sprite_height_i <= wd.h;
    first_byte_i    <= wd.first;
    sprite_byte_i   <= wd.pix;
    background_i    <= wd.bg;
    pixel_address_i <= wd.addr;
    in_valid_i      <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (blit_apply(wd, argb)) color_q.push_back(wd.chk ? wd.want : argb);
    n_words++;
    case (wd.func)
      sbf_pkg::FUNC_SPRITE: n_bytes++;
      sbf_pkg::FUNC_READ:   n_reads++;
      default:              n_sweeps++;
    endcase
  endtask

  // Output side: check every color word taken, then hold stall for a drawn number of cycles.
  initial begin
    int          hold;
    logic [31:0] want;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        n_checked++;
        if (color_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("color word %08h arrived with no read pending", pixel_argb_o);
        end else begin
          want = color_q.pop_front();
          if (pixel_argb_o !== want) begin
            n_bad++;
            if (n_bad <= 10)
              $display("pixel_argb mismatch: expected %08h, got %08h", want, pixel_argb_o);
          end
        end
        hold = no_idle ? 0 : $urandom_range(0, 12);
        if (hold != 0) out_stall_i <= 1'b1;
      end else if (out_stall_i && out_valid_o) begin
        hold--;
        if (hold == 0) out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    blit_word_t  dir_tab [$];
    logic [15:0] sx, sy;
    logic [7:0]  w, h;
    int          n, pick, rand_sweeps;

    for (int i = 0; i < NPIX; i++) begin
      fb_index[i] = 4'h0;
      fb_mark[i]  = 1'b1;
    end
    bg_reg      = 4'h0;
    col_cnt     = 8'd0;
    row_cnt     = 8'd0;
    rand_sweeps = 0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    dir_tab = '{
      rd(17'd0, 1'b1, 32'hFF000000),
      rd(17'(NPIX - 1), 1'b1, 32'hFF000000),
      rd(17'(NPIX), 1'b1, 32'h0),
      rd(17'h1FFFF, 1'b1, 32'h0),
      spr(16'd0, 16'd0, 8'd1, 8'd1, 1'b1, 8'hF1),
      rd(17'd0, 1'b1, 32'hFFFFFFFF),
      // Bottom right corner: the second word of the row falls past the last pixel.
      spr(16'd318, 16'd239, 8'd2, 8'd1, 1'b1, 8'h23),
      spr(16'd318, 16'd239, 8'd2, 8'd1, 1'b0, 8'h9A),
      rd(17'(NPIX - 1), 1'b1, 32'hFF3239BF),
      spr(16'hFFFF, 16'd0, 8'd1, 8'd1, 1'b1, 8'h45),
      spr(16'd319, 16'd0, 8'd1, 8'd1, 1'b1, 8'h67),
      rd(17'd320, 1'b0, 32'h0),
      spr(16'h8000, 16'h8000, 8'd255, 8'd255, 1'b1, 8'hFF),
      spr(16'h7FFF, 16'h7FFF, 8'd255, 8'd255, 1'b0, 8'hEE),
      // Zero width advances the row on every word; zero height pins it.
      spr(16'd10, 16'd10, 8'd0, 8'd0, 1'b1, 8'h89),
      spr(16'd10, 16'd10, 8'd0, 8'd3, 1'b0, 8'hAB),
      spr(16'd10, 16'd10, 8'd0, 8'd3, 1'b0, 8'hCD),
      rd(17'd3530, 1'b0, 32'h0),
      spr(16'd0, 16'd0, 8'd1, 8'd1, 1'b1, 8'h00),
      op(sbf_pkg::FUNC_SET_BG, 4'hF),
      rd(17'd0, 1'b0, 32'h0),
      op(sbf_pkg::FUNC_CLEAR, 4'h0),
      spr(16'd100, 16'd100, 8'd4, 8'd2, 1'b1, 8'hD0),
      op(sbf_pkg::FUNC_SET_BG, 4'h0),
      rd(17'd32100, 1'b0, 32'h0),
      rd(17'd32101, 1'b0, 32'h0)
    };
    foreach (dir_tab[k]) send_word(dir_tab[k]);

    while (n_words < dir_tab.size() + RANDOM_WORDS) begin
      if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        // Up to 24 bytes of a sprite in row order, sometimes 1 to 6 more, with reads that land on it.
        sx = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 339) - 10);
        sy = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 259) - 10);
        w  = pick_dim();
        h  = pick_dim();
        n  = ((w == 0) ? 1 : int'(w)) * ((h == 0) ? 1 : int'(h));
        if (n > 24) n = 24;
        if ($urandom_range(0, 7) == 0) n += $urandom_range(1, 6);
        for (int k = 0; k < n; k++) begin
          send_word(spr(sx, sy, w, h, k == 0, {rand_nib(), rand_nib()}));
          if ($urandom_range(0, 7) == 0) send_word(rd(foot_addr(sx, sy, w, h), 1'b0, 32'h0));
        end
        repeat ($urandom_range(1, 4)) send_word(rd(foot_addr(sx, sy, w, h), 1'b0, 32'h0));
      end else if (pick < 75) begin
        send_word(noise_word());
      end else if (pick < 99 || rand_sweeps >= MAX_SWEEPS) begin
        send_word(rd(($urandom_range(0, 1) == 0) ? 17'($urandom_range(0, NPIX - 1))
                                                 : 17'($urandom), 1'b0, 32'h0));
      end else begin
        rand_sweeps++;
        send_word(op(($urandom_range(0, 1) == 0) ? sbf_pkg::FUNC_CLEAR
                                                 : sbf_pkg::FUNC_SET_BG, 4'($urandom)));
      end
    end
    in_valid_i <= 1'b0;

    while (color_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("%0d words taken: %0d sprite bytes, %0d pixel reads, %0d full-screen sweeps",
             n_words, n_bytes, n_reads, n_sweeps);
    $display("%0d colors compared, %0d mismatches", n_checked, n_bad);
    if (n_bad == 0) begin
      $display("sprite_blit_framebuffer test passed");
    end else begin
      $display("sprite_blit_framebuffer test failed");
    end
    $finish;
  end

endmodule
